// ===== hdl/sacl_pkg.sv =====
// Shared types and constants for the set-associative tag lookup.
// No dependencies; imported by the victim select and top level.
`timescale 1ns / 1ps

package sacl_pkg;

   localparam int CNT_W = 32;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic [1:0] {
      OUTCOME_HIT     = 2'd0,
      OUTCOME_FILL    = 2'd1,
      OUTCOME_REPLACE = 2'd2
   } outcome_type;

   // saturating increment shared by all counters
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

// ===== hdl/set_assoc_cache_tag_lookup.sv =====
// Top level of the set-associative tag lookup: input register, tag RAM read,
// hit/victim decision and result register. Uses sacl_pkg, sacl_tag_ram, sacl_victim_sel.
`timescale 1ns / 1ps

// One lookup per clock while req_stall is low. A transaction's set row is
// read from the tag RAM at accept; the next cycle compares all ways in
// parallel and picks the victim on a miss. When the result register can take
// it, the stage writes the row back on a miss and loads the result register,
// so rsp_valid is registered from the lookup stage's advance. A lookup behind a
// miss on the same set takes the bypassed copy of the last row written. A
// stalled result holds the lookup stage and so the input. After reset the RAM
// is cleared one set per cycle and req_stall stays high meanwhile. Sets at or
// above 2^floor(log2(NUM_SETS)) are never addressed.
module set_assoc_cache_tag_lookup #(
   parameter int NUM_SETS    = 16,
   parameter int NUM_WAYS    = 2,
   parameter int BLOCK_BYTES = 4,
   parameter int ADDR_BITS   = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [31:0]                  req_address,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_outcome,
   output logic                         rsp_way_used,
   output logic [sacl_pkg::CNT_W-1:0]   rsp_access_count,
   output logic [sacl_pkg::CNT_W-1:0]   rsp_miss_count,
   output logic [sacl_pkg::CNT_W-1:0]   rsp_replace_count
);
   import sacl_pkg::*;

   localparam int OFF_BITS  = $clog2(BLOCK_BYTES + 1) - 1;
   localparam int IDX_BITS  = $clog2(NUM_SETS + 1) - 1;
   localparam int LOW_BITS  = OFF_BITS + IDX_BITS;
   localparam int TAG_BITS  = ADDR_BITS - LOW_BITS;
   localparam int TAG_W     = (TAG_BITS > 0) ? TAG_BITS : 1;
   localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int ENTRY_W   = 1 + CNT_W + TAG_W;
   localparam logic [63:0] ADDR_MASK = (ADDR_BITS >= 64) ? '1 : ((64'd1 << ADDR_BITS) - 64'd1);

   // entry layout: {valid, fill count, tag}
   typedef logic [NUM_WAYS-1:0][ENTRY_W-1:0] row_type;

   logic                req_accept;
   logic [63:0]         addr64;
   logic [IDX_BITS-1:0] req_set;
   logic [TAG_W-1:0]    req_tag;

   logic                s1_valid_ff, s1_valid_in;
   logic [IDX_BITS-1:0] s1_set_ff;
   logic [TAG_W-1:0]    s1_tag_ff;
   logic                s1_adv;

   logic                ram_busy;
   row_type             ram_row;
   row_type             row_eff;
   row_type             row_new;
   logic                wr_en;

   logic                fwd_valid_ff;
   logic [IDX_BITS-1:0] fwd_set_ff;
   row_type             fwd_row_ff;

   logic [NUM_WAYS-1:0]            way_valid;
   logic [NUM_WAYS-1:0][CNT_W-1:0] way_cnt;
   logic [NUM_WAYS-1:0]            hit_vec;
   logic                           hit;
   logic [WAY_W-1:0]               hit_way;
   logic [WAY_W-1:0]               victim;
   logic [WAY_W-1:0]               pick;
   outcome_type                    outcome;

   logic [CNT_W-1:0] acc_total_ff, acc_total_in;
   logic [CNT_W-1:0] miss_total_ff, miss_total_in;
   logic [CNT_W-1:0] repl_total_ff, repl_total_in;

   logic              rsp_valid_ff, rsp_valid_in;
   outcome_type       rsp_outcome_ff;
   logic              rsp_way_ff;
   logic [CNT_W-1:0]  rsp_acc_ff, rsp_miss_ff, rsp_repl_ff;

   // ---------------- input side ----------------
   assign addr64     = {32'd0, req_address} & ADDR_MASK;
   assign req_set    = addr64[OFF_BITS +: IDX_BITS];
   assign req_tag    = TAG_W'(addr64 >> LOW_BITS);

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = ram_busy || (s1_valid_ff && !s1_adv);
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_set_ff <= req_set;
         s1_tag_ff <= req_tag;
      end
   end

   sacl_tag_ram #(
      .SET_BITS (IDX_BITS),
      .NUM_WAYS (NUM_WAYS),
      .ENTRY_W  (ENTRY_W)
   ) u_tag_ram (
      .clock  (clock),
      .reset  (reset),
      .busy   (ram_busy),
      .rd_en  (req_accept),
      .rd_set (req_set),
      .rd_row (ram_row),
      .wr_en  (wr_en),
      .wr_set (s1_set_ff),
      .wr_row (row_new)
   );

   // ---------------- lookup stage ----------------
   // last written row is always the newest copy of its set
   assign row_eff = (fwd_valid_ff && fwd_set_ff == s1_set_ff) ? fwd_row_ff : ram_row;

   always_comb begin
      hit_way = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         way_valid[w] = row_eff[w][ENTRY_W-1];
         way_cnt[w]   = row_eff[w][TAG_W +: CNT_W];
         hit_vec[w]   = way_valid[w] && (row_eff[w][TAG_W-1:0] == s1_tag_ff);
         hit_way      = hit_way | (hit_vec[w] ? WAY_W'(w) : '0);
      end
   end

   assign hit = |hit_vec;

   sacl_victim_sel #(
      .NUM_WAYS (NUM_WAYS),
      .WAY_W    (WAY_W)
   ) u_victim (
      .counts (way_cnt),
      .pick   (victim)
   );

   assign pick = hit ? hit_way : victim;

   always_comb begin
      row_new = row_eff;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (WAY_W'(w) == victim) begin
            row_new[w] = {1'b1, sat_inc(way_cnt[w]), s1_tag_ff};
         end
      end
   end

   always_comb begin
      if (hit) begin
         outcome = OUTCOME_HIT;
      end else if (way_valid[victim]) begin
         outcome = OUTCOME_REPLACE;
      end else begin
         outcome = OUTCOME_FILL;
      end
   end

   assign wr_en = s1_adv && !hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (wr_en) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_set_ff <= s1_set_ff;
         fwd_row_ff <= row_new;
      end
   end

   // ---------------- running totals ----------------
   always_comb begin
      acc_total_in  = acc_total_ff;
      miss_total_in = miss_total_ff;
      repl_total_in = repl_total_ff;
      if (s1_adv) begin
         acc_total_in = sat_inc(acc_total_ff);
         if (!hit) begin
            miss_total_in = sat_inc(miss_total_ff);
         end
         if (outcome == OUTCOME_REPLACE) begin
            repl_total_in = sat_inc(repl_total_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_total_ff  <= '0;
         miss_total_ff <= '0;
         repl_total_ff <= '0;
      end else begin
         acc_total_ff  <= acc_total_in;
         miss_total_ff <= miss_total_in;
         repl_total_ff <= repl_total_in;
      end
   end

   // ---------------- result register ----------------
   assign rsp_valid_in = s1_adv ? 1'b1 : ((rsp_valid_ff && rsp_stall) ? 1'b1 : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_outcome_ff <= outcome;
         rsp_way_ff     <= pick[0];
         rsp_acc_ff     <= acc_total_in;
         rsp_miss_ff    <= miss_total_in;
         rsp_repl_ff    <= repl_total_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_outcome       = rsp_outcome_ff;
   assign rsp_way_used      = rsp_way_ff;
   assign rsp_access_count  = rsp_acc_ff;
   assign rsp_miss_count    = rsp_miss_ff;
   assign rsp_replace_count = rsp_repl_ff;

   // ---------------- assertions ----------------
   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset) ram_busy |-> req_stall
   ) else $error("transaction accepted during tag RAM clear");

   a_lookup_lands_in_result: assert property (
      @(posedge clock) disable iff (reset) s1_adv |=> rsp_valid
   ) else $error("lookup result not registered");

   a_hit_keeps_miss_total: assert property (
      @(posedge clock) disable iff (reset) (s1_adv && hit) |=> $stable(miss_total_ff)
   ) else $error("miss total moved on a hit");

   a_replace_implies_miss: assert property (
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_outcome_ff == OUTCOME_REPLACE) |-> (rsp_miss_ff != '0)
   ) else $error("replacement reported with zero misses");

endmodule

// ===== hdl/sacl_tag_ram.sv =====
// Tag store: one row per set holding valid, fill count and tag of every way.
// Runs a clearing sweep after reset. No package dependencies.
`timescale 1ns / 1ps

module sacl_tag_ram #(
   parameter int SET_BITS = 4,
   parameter int NUM_WAYS = 2,
   parameter int ENTRY_W  = 59
) (
   input  logic                               clock,
   input  logic                               reset,
   output logic                               busy,
   input  logic                               rd_en,
   input  logic [SET_BITS-1:0]                rd_set,
   output logic [NUM_WAYS-1:0][ENTRY_W-1:0]   rd_row,
   input  logic                               wr_en,
   input  logic [SET_BITS-1:0]                wr_set,
   input  logic [NUM_WAYS-1:0][ENTRY_W-1:0]   wr_row
);

   localparam int DEPTH = 1 << SET_BITS;

   logic [NUM_WAYS-1:0][ENTRY_W-1:0] mem [DEPTH];
   logic [NUM_WAYS-1:0][ENTRY_W-1:0] rd_row_ff;
   logic                             busy_ff, busy_in;
   logic [SET_BITS-1:0]              ptr_ff, ptr_in;
   logic                             we;
   logic [SET_BITS-1:0]              wa;
   logic [NUM_WAYS-1:0][ENTRY_W-1:0] wd;

   // clear sweep after reset: one set per cycle, covering all DEPTH sets
   always_comb begin
      busy_in = busy_ff;
      ptr_in  = ptr_ff;
      if (busy_ff) begin
         ptr_in = ptr_ff + 1'b1;
         if (ptr_ff == SET_BITS'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         ptr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         ptr_ff  <= ptr_in;
      end
   end

   assign we = busy_ff | wr_en;
   assign wa = busy_ff ? ptr_ff : wr_set;
   assign wd = busy_ff ? '0 : wr_row;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         rd_row_ff <= mem[rd_set];
      end
   end

   assign rd_row = rd_row_ff;
   assign busy   = busy_ff;

endmodule

// ===== hdl/sacl_victim_sel.sv =====
// Victim select: lowest way with the smallest fill count, via a compare tree.
// Depends on sacl_pkg for the counter width.
`timescale 1ns / 1ps

module sacl_victim_sel #(
   parameter int NUM_WAYS = 2,
   parameter int WAY_W    = 1
) (
   input  logic [NUM_WAYS-1:0][sacl_pkg::CNT_W-1:0] counts,
   output logic [WAY_W-1:0]                         pick
);
   import sacl_pkg::*;

   localparam int LVLS  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 0;
   localparam int P     = 1 << LVLS;
   localparam int NODES = 2 * P - 1;

   logic [CNT_W-1:0] node_cnt [NODES];
   logic [WAY_W-1:0] node_idx [NODES];

   // heap layout: leaves at P-1.., padding leaves lose every tie (left wins)
   for (genvar i = 0; i < P; i++) begin : g_leaf
      if (i < NUM_WAYS) begin : g_real
         assign node_cnt[P-1+i] = counts[i];
         assign node_idx[P-1+i] = WAY_W'(i);
      end else begin : g_pad
         assign node_cnt[P-1+i] = CNT_MAX;
         assign node_idx[P-1+i] = '0;
      end
   end

   for (genvar n = 0; n < P - 1; n++) begin : g_node
      logic take_left;
      assign take_left   = node_cnt[2*n+1] <= node_cnt[2*n+2];
      assign node_cnt[n] = take_left ? node_cnt[2*n+1] : node_cnt[2*n+2];
      assign node_idx[n] = take_left ? node_idx[2*n+1] : node_idx[2*n+2];
   end

   assign pick = node_idx[0];

endmodule
